/* rtl/cspf_pkg.sv */
`timescale 1ns / 1ps

package cspf_pkg;

    // default sizes
    localparam int NUM_LIBS_DEF      = 16;
    localparam int FUNCS_PER_LIB_DEF = 1024;
    localparam int STACK_DEPTH_DEF   = 64;

    // field widths
    localparam int CMD_W    = 2;
    localparam int LIB_ID_W = 4;
    localparam int FUNC_W   = 10;
    localparam int TS_W     = 48;
    localparam int CALLS_W  = 32;
    localparam int TOTAL_W  = 48;
    localparam int LEVEL_W  = 7;
    localparam int STATUS_W = 2;

    localparam int S_DATA_W = 64;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 144;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ENTRY = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EXIT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_BLOCK = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 2'd2;

    // one profile table row
    typedef struct packed {
        logic [TOTAL_W-1:0] blocks;
        logic [TOTAL_W-1:0] cycles;
        logic [CALLS_W-1:0] calls;
    } tbl_row_t;

    // table port control
    typedef struct packed {
        logic rd;
        logic wr;
    } tbl_cmd_t;

    // stack port control
    typedef struct packed {
        logic rd;
        logic wr;
    } stk_cmd_t;

    function automatic logic [TOTAL_W-1:0] sat_add48(input logic [TOTAL_W-1:0] a,
                                                     input logic [TOTAL_W-1:0] b);
        logic [TOTAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
    endfunction

    function automatic logic [CALLS_W-1:0] sat_inc32(input logic [CALLS_W-1:0] a);
        return (a == {CALLS_W{1'b1}}) ? a : a + 1'b1;
    endfunction

endpackage

/* rtl/cspf_index.sv */
`timescale 1ns / 1ps

module cspf_index #(
    parameter int NUM_LIBS      = cspf_pkg::NUM_LIBS_DEF,
    parameter int FUNCS_PER_LIB = cspf_pkg::FUNCS_PER_LIB_DEF,
    parameter int ROW_W         = 14
) (
    input  logic                          clk,
    input  logic [cspf_pkg::LIB_ID_W-1:0] lib_id,
    input  logic [cspf_pkg::FUNC_W-1:0]   func_id,
    output logic [ROW_W-1:0]              row
);

    // reciprocal division: exact floor for 10-bit dividends with a 20-bit shift
    localparam int QSH = 20;
    localparam int LIB_W  = (NUM_LIBS > 1) ? $clog2(NUM_LIBS) : 1;
    localparam int FNC_W  = (FUNCS_PER_LIB > 1) ? $clog2(FUNCS_PER_LIB) : 1;
    localparam logic [QSH:0] LIB_RECIP  = (QSH+1)'((2**QSH + NUM_LIBS - 1) / NUM_LIBS);
    localparam logic [QSH:0] FUNC_RECIP =
        (QSH+1)'((2**QSH + FUNCS_PER_LIB - 1) / FUNCS_PER_LIB);

    localparam int XW = cspf_pkg::FUNC_W;

    logic [XW-1:0]      lib_x;
    logic [29:0]        lib_prod;
    logic [29:0]        func_prod;
    logic [XW-1:0]      lib_q_reg;
    logic [XW-1:0]      func_q_reg;
    logic [31:0]        lib_back;
    logic [31:0]        func_back;
    logic [XW-1:0]      lib_diff;
    logic [XW-1:0]      func_diff;
    logic [LIB_W-1:0]   lib_r_reg;
    logic [FNC_W-1:0]   func_r_reg;
    logic [31:0]        row_sum;
    logic [ROW_W-1:0]   row_reg;

    assign lib_x     = XW'(lib_id);
    assign lib_prod  = 30'(lib_x) * 30'(LIB_RECIP);
    assign func_prod = 30'(func_id) * 30'(FUNC_RECIP);

    // remainder from the registered quotient
    assign lib_back  = 32'(lib_q_reg) * 32'(NUM_LIBS);
    assign func_back = 32'(func_q_reg) * 32'(FUNCS_PER_LIB);
    assign lib_diff  = lib_x - lib_back[XW-1:0];
    assign func_diff = func_id - func_back[XW-1:0];

    assign row_sum = 32'(lib_r_reg) * 32'(FUNCS_PER_LIB) + 32'(func_r_reg);

    always_ff @(posedge clk)
    begin
        lib_q_reg  <= lib_prod[QSH+XW-1:QSH];
        func_q_reg <= func_prod[QSH+XW-1:QSH];
        lib_r_reg  <= LIB_W'(lib_diff);
        func_r_reg <= FNC_W'(func_diff);
        row_reg    <= row_sum[ROW_W-1:0];
    end

    assign row = row_reg;

endmodule

/* rtl/cspf_table.sv */
`timescale 1ns / 1ps

module cspf_table #(
    parameter int ROWS  = cspf_pkg::NUM_LIBS_DEF * cspf_pkg::FUNCS_PER_LIB_DEF,
    parameter int ROW_W = 14
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cspf_pkg::tbl_cmd_t cmd,
    input  logic [ROW_W-1:0]   addr,
    input  cspf_pkg::tbl_row_t wdata,
    output cspf_pkg::tbl_row_t rdata,
    output logic               busy
);

    cspf_pkg::tbl_row_t mem [ROWS];
    cspf_pkg::tbl_row_t rdata_reg;

    logic             clr_busy_reg;
    logic             clr_busy_next;
    logic [ROW_W-1:0] clr_addr_reg;
    logic [ROW_W-1:0] clr_addr_next;

    // zero sweep after reset, one row per cycle
    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == ROW_W'(ROWS - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (cmd.wr)
        begin
            mem[addr] <= wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;
    assign busy  = clr_busy_reg;

endmodule

/* rtl/cspf_stack.sv */
`timescale 1ns / 1ps

module cspf_stack #(
    parameter int DEPTH = cspf_pkg::STACK_DEPTH_DEF,
    parameter int SP_W  = 6,
    parameter int ROW_W = 14
) (
    input  logic               clk,
    input  cspf_pkg::stk_cmd_t cmd,
    input  logic [SP_W-1:0]    rd_idx,
    input  logic [SP_W-1:0]    wr_idx,
    input  logic [ROW_W-1:0]   wdata,
    output logic [ROW_W-1:0]   rdata
);

    logic [ROW_W-1:0] mem [DEPTH];
    logic [ROW_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[wr_idx] <= wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[rd_idx];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/call_stack_exclusive_profiler_core.sv */
// sequence: basic block and ignored entry/exit go straight to ST_FIN; exit runs ST_TOP,
// ST_CR_WR; read runs ST_IXA, ST_IXB, ST_IXC, ST_DISP; entry runs those, ST_ENT_WR, then
// ST_CR_RD, ST_CR_WR on a nonempty stack; ST_FIN waits for a free result register
// requests: one at a time, paced by the single-port profile table (one read-modify-write
// per touched row) and the 3-stage row index multiply pipeline; reset: rst_n async, then
// a zero sweep of the NUM_LIBS*FUNCS_PER_LIB rows (16384 by default), taking no request
`timescale 1ns / 1ps

module call_stack_exclusive_profiler_core #(
    parameter int NUM_LIBS      = cspf_pkg::NUM_LIBS_DEF,
    parameter int FUNCS_PER_LIB = cspf_pkg::FUNCS_PER_LIB_DEF,
    parameter int STACK_DEPTH   = cspf_pkg::STACK_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request side
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // lib_id [3:0], func_id [13:4], timestamp [61:14], zero fill [63:62]
    input  logic [cspf_pkg::S_DATA_W-1:0] s_tdata,
    // cmd [1:0]
    input  logic [cspf_pkg::S_USER_W-1:0] s_tuser,
    // result side
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // call_count [31:0], cycle_total [79:32], block_total [127:80],
    // stack_level [134:128], status [136:135], zero fill [143:137]
    output logic [cspf_pkg::M_DATA_W-1:0] m_tdata
);

    localparam int ROWS  = NUM_LIBS * FUNCS_PER_LIB;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SP_W  = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    localparam int TS_W    = cspf_pkg::TS_W;
    localparam int TOT_W   = cspf_pkg::TOTAL_W;
    localparam int CALLS_W = cspf_pkg::CALLS_W;
    localparam int LEVEL_W = cspf_pkg::LEVEL_W;
    localparam int STAT_W  = cspf_pkg::STATUS_W;
    localparam int PAD_W   = cspf_pkg::M_DATA_W - CALLS_W - 2*TOT_W - LEVEL_W - STAT_W;

    // sequencer states
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_IXA    = 4'd1;  // index pipeline, quotient
    localparam logic [3:0] ST_IXB    = 4'd2;  // index pipeline, remainder
    localparam logic [3:0] ST_IXC    = 4'd3;  // index pipeline, row
    localparam logic [3:0] ST_DISP   = 4'd4;  // read addressed row
    localparam logic [3:0] ST_ENT_WR = 4'd5;  // bump call count, push
    localparam logic [3:0] ST_TOP    = 4'd6;  // stack top arrives, read its row
    localparam logic [3:0] ST_CR_RD  = 4'd7;  // read caller row
    localparam logic [3:0] ST_CR_WR  = 4'd8;  // credit cycles and blocks
    localparam logic [3:0] ST_FIN    = 4'd9;  // commit and present result

    logic [3:0]                     state_reg;
    logic [3:0]                     state_next;

    // request held for the whole sequence
    logic [cspf_pkg::CMD_W-1:0]     cmd_reg;
    logic [cspf_pkg::LIB_ID_W-1:0]  lib_reg;
    logic [cspf_pkg::FUNC_W-1:0]    func_reg;
    logic [TS_W-1:0]                ts_reg;
    logic [STAT_W-1:0]              status_reg;
    logic [STAT_W-1:0]              status_next;

    // profiler context
    logic [CNT_W-1:0]               count_reg;
    logic [CNT_W-1:0]               count_next;
    logic [CNT_W-1:0]               count_dec;
    logic [TS_W-1:0]                start_reg;
    logic [TS_W-1:0]                start_next;
    logic [TOT_W-1:0]               pending_reg;
    logic [TOT_W-1:0]               pending_next;
    logic [ROW_W-1:0]               top_reg;
    logic [ROW_W-1:0]               top_next;

    // result register
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [cspf_pkg::M_DATA_W-1:0]  out_data_reg;
    logic [cspf_pkg::M_DATA_W-1:0]  out_data_next;

    logic                           accept;
    logic                           out_free;
    logic                           clr_busy;
    logic [ROW_W-1:0]               row;

    cspf_pkg::tbl_cmd_t             tbl_cmd;
    logic [ROW_W-1:0]               tbl_addr;
    cspf_pkg::tbl_row_t             tbl_wdata;
    cspf_pkg::tbl_row_t             tbl_rdata;
    cspf_pkg::tbl_row_t             entry_row;
    cspf_pkg::tbl_row_t             credit_row;

    cspf_pkg::stk_cmd_t             stk_cmd;
    logic [ROW_W-1:0]               stk_rdata;

    logic [cspf_pkg::CMD_W-1:0]     in_cmd;
    logic [TS_W-1:0]                elapsed;
    logic [TOT_W-1:0]               res_calls;
    logic [TOT_W-1:0]               res_cycles;
    logic [TOT_W-1:0]               res_blocks;

    assign in_cmd   = s_tuser[cspf_pkg::CMD_W-1:0];
    assign s_tready = (state_reg == ST_IDLE) && !clr_busy;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign count_dec = count_reg - 1'b1;

    // row = lib_id mod NUM_LIBS * FUNCS_PER_LIB + func_id mod FUNCS_PER_LIB
    cspf_index #(
        .NUM_LIBS      (NUM_LIBS),
        .FUNCS_PER_LIB (FUNCS_PER_LIB),
        .ROW_W         (ROW_W)
    ) u_index (
        .clk     (clk),
        .lib_id  (lib_reg),
        .func_id (func_reg),
        .row     (row)
    );

    cspf_table #(
        .ROWS  (ROWS),
        .ROW_W (ROW_W)
    ) u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (tbl_cmd),
        .addr  (tbl_addr),
        .wdata (tbl_wdata),
        .rdata (tbl_rdata),
        .busy  (clr_busy)
    );

    cspf_stack #(
        .DEPTH (STACK_DEPTH),
        .SP_W  (SP_W),
        .ROW_W (ROW_W)
    ) u_stack (
        .clk    (clk),
        .cmd    (stk_cmd),
        .rd_idx (count_dec[SP_W-1:0]),
        .wr_idx (count_reg[SP_W-1:0]),
        .wdata  (row),
        .rdata  (stk_rdata)
    );

    // row updates, taken from the registered table read
    assign elapsed = ts_reg - start_reg;

    always_comb
    begin
        entry_row        = tbl_rdata;
        entry_row.calls  = cspf_pkg::sat_inc32(tbl_rdata.calls);
        credit_row       = tbl_rdata;
        credit_row.cycles = cspf_pkg::sat_add48(tbl_rdata.cycles, elapsed);
        credit_row.blocks = cspf_pkg::sat_add48(tbl_rdata.blocks, pending_reg);
    end

    // table results appear only on a read request
    assign res_calls  = (cmd_reg == cspf_pkg::CMD_READ) ? TOT_W'(tbl_rdata.calls) : '0;
    assign res_cycles = (cmd_reg == cspf_pkg::CMD_READ) ? tbl_rdata.cycles : '0;
    assign res_blocks = (cmd_reg == cspf_pkg::CMD_READ) ? tbl_rdata.blocks : '0;

    always_comb
    begin
        state_next     = state_reg;
        status_next    = status_reg;
        count_next     = count_reg;
        start_next     = start_reg;
        pending_next   = pending_reg;
        top_next       = top_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        tbl_cmd        = '0;
        tbl_addr       = row;
        tbl_wdata      = entry_row;
        stk_cmd        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    status_next = cspf_pkg::STAT_OK;
                    unique case (in_cmd)
                        cspf_pkg::CMD_ENTRY:
                        begin
                            if (count_reg == CNT_W'(STACK_DEPTH))
                            begin
                                status_next = cspf_pkg::STAT_OVERFLOW;
                                state_next  = ST_FIN;
                            end
                            else
                            begin
                                // fetch the caller id while the row index settles
                                stk_cmd.rd = 1'b1;
                                state_next = ST_IXA;
                            end
                        end
                        cspf_pkg::CMD_EXIT:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = cspf_pkg::STAT_UNDERFLOW;
                                state_next  = ST_FIN;
                            end
                            else
                            begin
                                stk_cmd.rd = 1'b1;
                                state_next = ST_TOP;
                            end
                        end
                        cspf_pkg::CMD_BLOCK:
                        begin
                            state_next = ST_FIN;
                        end
                        cspf_pkg::CMD_READ:
                        begin
                            state_next = ST_IXA;
                        end
                        default:
                        begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_IXA:
            begin
                top_next   = stk_rdata;
                state_next = ST_IXB;
            end
            ST_IXB:
            begin
                state_next = ST_IXC;
            end
            ST_IXC:
            begin
                state_next = ST_DISP;
            end
            ST_DISP:
            begin
                tbl_cmd.rd = 1'b1;
                state_next = (cmd_reg == cspf_pkg::CMD_ENTRY) ? ST_ENT_WR : ST_FIN;
            end
            ST_ENT_WR:
            begin
                // the caller row is read only after this write, so recursion sees it
                tbl_cmd.wr = 1'b1;
                stk_cmd.wr = 1'b1;
                state_next = (count_reg != '0) ? ST_CR_RD : ST_FIN;
            end
            ST_TOP:
            begin
                top_next   = stk_rdata;
                tbl_cmd.rd = 1'b1;
                tbl_addr   = stk_rdata;
                state_next = ST_CR_WR;
            end
            ST_CR_RD:
            begin
                tbl_cmd.rd = 1'b1;
                tbl_addr   = top_reg;
                state_next = ST_CR_WR;
            end
            ST_CR_WR:
            begin
                tbl_cmd.wr   = 1'b1;
                tbl_addr     = top_reg;
                tbl_wdata    = credit_row;
                pending_next = '0;
                state_next   = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    if (status_reg == cspf_pkg::STAT_OK)
                    begin
                        unique case (cmd_reg)
                            cspf_pkg::CMD_ENTRY:
                            begin
                                count_next = count_reg + 1'b1;
                                start_next = ts_reg;
                            end
                            cspf_pkg::CMD_EXIT:
                            begin
                                count_next = count_dec;
                                if (count_dec != '0)
                                begin
                                    start_next = ts_reg;
                                end
                            end
                            cspf_pkg::CMD_BLOCK:
                            begin
                                pending_next = cspf_pkg::sat_add48(pending_reg, TOT_W'(1));
                            end
                            default:
                            begin
                                count_next = count_reg;
                            end
                        endcase
                    end
                    out_valid_next = 1'b1;
                    out_data_next  = {PAD_W'(0), status_reg, LEVEL_W'(count_next),
                                      res_blocks, res_cycles, res_calls[CALLS_W-1:0]};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            start_reg     <= '0;
            pending_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            start_reg     <= start_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= in_cmd;
            lib_reg  <= s_tdata[3:0];
            func_reg <= s_tdata[13:4];
            ts_reg   <= s_tdata[61:14];
        end
        status_reg   <= status_next;
        top_reg      <= top_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // stack depth stays within the configured stack
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack depth above limit");

    // no request is taken during the table sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy |-> !s_tready)
        else $error("request taken while table clears");

    // an accepted request always starts a sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != ST_IDLE)
        else $error("request dropped");

    // an ignored exit reports an empty stack
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[136:135] == cspf_pkg::STAT_UNDERFLOW) |-> m_tdata[134:128] == '0)
        else $error("underflow with nonempty stack");
`endif

endmodule
